[sv/r2fft_pkg.sv]
package r2fft_pkg;

  localparam int unsigned DATA_W = 32;
  localparam logic [3:0]  LOG2_POINTS_RESET = 4'd10;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // product terms of the complex multiply v = x * w
  localparam logic [1:0] TERM_RR = 2'd0;  // xr * wr
  localparam logic [1:0] TERM_II = 2'd1;  // xi * wi
  localparam logic [1:0] TERM_RI = 2'd2;  // xr * wi
  localparam logic [1:0] TERM_IR = 2'd3;  // xi * wr

  typedef struct packed {
    logic       mul;
    logic [1:0] term;
  } bf_ctl_t;

endpackage

[sv/r2fft_twrom.sv]
module r2fft_twrom #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned TWIDDLE_BITS = 16,
  parameter int unsigned TW_AW        = 9
) (
  input  logic                           clk_i,
  input  logic [TW_AW-1:0]               addr_i,
  output logic signed [TWIDDLE_BITS-1:0] w_re_o,
  output logic signed [TWIDDLE_BITS-1:0] w_im_o
);

  localparam int unsigned HALF = MAX_POINTS / 2;
  localparam int unsigned TB   = TWIDDLE_BITS;

  // round half up of cos or -sin scaled by 2^(TB-1), clamped to the signed range
  function automatic logic [TB-1:0] tw_val(input int k, input bit im);
    real   a;
    real   v;
    real   r;
    longint t;
    longint top;
    a   = 6.283185307179586476925 * k / MAX_POINTS;
    v   = im ? -$sin(a) : $cos(a);
    r   = $floor(v * (2.0 ** (TB - 1)) + 0.5);
    t   = longint'(r);
    top = (longint'(1) <<< (TB - 1)) - 1;
    if (t > top) t = top;
    if (t < -top - 1) t = -top - 1;
    return TB'(t);
  endfunction

  logic [2*TB-1:0] rom [HALF];
  logic [2*TB-1:0] rd_q;

  for (genvar g = 0; g < HALF; g++) begin : g_rom
    assign rom[g] = {tw_val(g, 1'b0), tw_val(g, 1'b1)};
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rom[addr_i];
  end

  assign w_re_o = rd_q[2*TB-1:TB];
  assign w_im_o = rd_q[TB-1:0];

endmodule

[sv/r2fft_bfly.sv]
module r2fft_bfly #(
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  r2fft_pkg::bf_ctl_t             ctl_i,
  input  logic signed [31:0]             u_re_i,
  input  logic signed [31:0]             u_im_i,
  input  logic signed [31:0]             x_re_i,
  input  logic signed [31:0]             x_im_i,
  input  logic signed [TWIDDLE_BITS-1:0] w_re_i,
  input  logic signed [TWIDDLE_BITS-1:0] w_im_i,
  output logic [31:0]                    sum_re_o,
  output logic [31:0]                    sum_im_o,
  output logic [31:0]                    dif_re_o,
  output logic [31:0]                    dif_im_o
);
  import r2fft_pkg::*;

  localparam int unsigned PW  = DATA_W + TWIDDLE_BITS;
  localparam int unsigned AW2 = PW + 1;
  localparam int unsigned SH  = TWIDDLE_BITS - 1;
  localparam int unsigned VW  = AW2 - SH;
  localparam int unsigned SW  = VW + 1;
  localparam logic signed [AW2-1:0] RND = AW2'(1) << (SH - 1);

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic [31:0] r;
    if (v > SW'(32'sh7fffffff))       r = 32'h7fffffff;
    else if (v < -SW'(32'sh7fffffff) - SW'(1)) r = 32'h80000000;
    else                              r = v[31:0];
    return r;
  endfunction

  logic signed [31:0]           ma;
  logic signed [TWIDDLE_BITS-1:0] mb;
  logic signed [PW-1:0]         prod_q;
  logic [1:0]                   term_q;
  logic                         pv_q;
  logic signed [AW2-1:0]        vr_q, vi_q;
  logic signed [AW2-1:0]        pe;
  logic signed [AW2-1:0]        vr_t, vi_t;
  logic signed [SW-1:0]         vr, vi, ur, ui;

  always_comb begin
    case (ctl_i.term)
      TERM_RR: begin ma = x_re_i; mb = w_re_i; end
      TERM_II: begin ma = x_im_i; mb = w_im_i; end
      TERM_RI: begin ma = x_re_i; mb = w_im_i; end
      TERM_IR: begin ma = x_im_i; mb = w_re_i; end
      default: begin ma = x_re_i; mb = w_re_i; end
    endcase
  end

  assign pe = {prod_q[PW-1], prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      term_q <= TERM_RR;
    end else begin
      pv_q   <= ctl_i.mul;
      term_q <= ctl_i.term;
    end
  end

  // one product per cycle, accumulated the cycle after
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (pv_q) begin
      case (term_q)
        TERM_RR: vr_q <= pe;
        TERM_II: vr_q <= vr_q - pe;
        TERM_RI: vi_q <= pe;
        TERM_IR: vi_q <= vi_q + pe;
        default: vr_q <= vr_q;
      endcase
    end
  end

  // floor shift after adding half: round half up
  assign vr_t = vr_q + RND;
  assign vi_t = vi_q + RND;
  assign vr   = {vr_t[AW2-1], vr_t[AW2-1:SH]};
  assign vi   = {vi_t[AW2-1], vi_t[AW2-1:SH]};
  assign ur   = {{(SW-32){u_re_i[31]}}, u_re_i};
  assign ui   = {{(SW-32){u_im_i[31]}}, u_im_i};

  assign sum_re_o = sat32(ur + vr);
  assign sum_im_o = sat32(ui + vi);
  assign dif_re_o = sat32(ur - vr);
  assign dif_im_o = sat32(ui - vi);

endmodule

[sv/radix2_fft_top.sv]
// Load item: taken while idle; busy stays low unless it completes a frame.
// Read item: bin strobed in the cycle after acceptance, busy during that cycle.
// Frame-completing load: busy through the permutation and all butterfly stages, a span set by
// the single-port point store and the one shared multiplier.
// Output strobe cannot be stalled; results are never back to back.
// Reset (async, active low) clears counters and FSM, length back to 1024; store is undefined.
module radix2_fft_top #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i,
  output logic               bin_valid_o,
  output logic signed [31:0] bin_re_o,
  output logic signed [31:0] bin_im_o,
  output logic [9:0]         bin_index_o,
  output logic               last_bin_o
);
  import r2fft_pkg::*;

  localparam int unsigned LMAX  = $clog2(MAX_POINTS);
  localparam int unsigned AW    = LMAX;
  localparam int unsigned CW    = LMAX + 1;
  localparam int unsigned LW    = $clog2(LMAX + 1);
  localparam int unsigned TW_AW = (LMAX > 1) ? LMAX - 1 : 1;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_RD_OUT = 13'b0000000000010,
    S_BR_RDI = 13'b0000000000100,
    S_BR_RDY = 13'b0000000001000,
    S_BR_WRI = 13'b0000000010000,
    S_BR_WRY = 13'b0000000100000,
    S_BF_RDP = 13'b0000001000000,
    S_BF_RDS = 13'b0000010000000,
    S_BF_X   = 13'b0000100000000,
    S_BF_MUL = 13'b0001000000000,
    S_BF_ACC = 13'b0010000000000,
    S_BF_WRP = 13'b0100000000000,
    S_BF_WRS = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      cfg_q;
  logic [CW-1:0]   load_q, load_d;
  logic [CW-1:0]   read_q, read_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [LW-1:0]   st_q, st_d;
  logic [1:0]      term_q, term_d;
  logic [63:0]     a_q, a_d;
  logic [63:0]     x_q, x_d;

  // point store: {re, im} per entry, one port, registered read
  logic [63:0]     mem [MAX_POINTS];
  logic [63:0]     mem_rd_q;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic [63:0]     mem_wdata;

  logic [LW-1:0]   lg;
  logic [CW-1:0]   n_cw, n_m1, half_m1, rd_idx, load_inc;
  logic [AW-1:0]   bi, rev_full, ry;
  logic [AW-1:0]   hm, jj, p_addr, s_addr;
  logic [TW_AW-1:0] tw_idx;
  bf_ctl_t         bf_ctl;
  logic signed [TWIDDLE_BITS-1:0] w_re, w_im;
  logic [31:0]     sum_re, sum_im, dif_re, dif_im;

  // clamp configured length into 1..LMAX
  always_comb begin
    if (cfg_q == 4'd0)           lg = LW'(1);
    else if (32'(cfg_q) > LMAX)  lg = LW'(LMAX);
    else                         lg = LW'(cfg_q);
  end

  assign n_cw     = CW'(1) << lg;
  assign n_m1     = n_cw - CW'(1);
  assign half_m1  = (n_cw >> 1) - CW'(1);
  assign rd_idx   = (read_q < n_cw) ? read_q : '0;
  assign load_inc = load_q + CW'(1);

  // bit-reversed partner of index bi within lg bits
  assign bi = cnt_q[AW-1:0];
  always_comb begin
    for (int k = 0; k < AW; k++) begin
      rev_full[k] = bi[AW-1-k];
    end
  end
  assign ry = rev_full >> (LW'(LMAX) - lg);

  // butterfly addressing: stage st_q pairs p and p + half
  assign hm     = AW'((CW'(1) << (st_q - LW'(1))) - CW'(1));
  assign jj     = bi & hm;
  assign p_addr = AW'({(bi & ~hm), 1'b0}) | jj;
  assign s_addr = p_addr | (hm + AW'(1));
  assign tw_idx = TW_AW'(jj << (LW'(LMAX) - st_q));

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    read_d    = read_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    st_d      = st_q;
    term_d    = term_q;
    a_d       = a_q;
    x_d       = x_q;
    mem_we    = 1'b0;
    mem_addr  = p_addr;
    mem_wdata = {sum_re, sum_im};
    bf_ctl    = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_LOAD) begin
            mem_we    = 1'b1;
            mem_addr  = load_q[AW-1:0];
            mem_wdata = {{16{sample_re_i[15]}}, sample_re_i,
                         {16{sample_im_i[15]}}, sample_im_i};
            load_d    = load_inc;
            if (load_inc >= n_cw) begin
              // frame complete: permute, then run the stages
              load_d  = '0;
              read_d  = '0;
              cnt_d   = '0;
              state_d = S_BR_RDI;
            end
          end else begin
            mem_addr = rd_idx[AW-1:0];
            idx_d    = rd_idx;
            read_d   = (rd_idx + CW'(1) >= n_cw) ? '0 : rd_idx + CW'(1);
            state_d  = S_RD_OUT;
          end
        end
      end
      S_RD_OUT: state_d = S_IDLE;
      S_BR_RDI: begin
        mem_addr = bi;
        if (bi < ry) begin
          state_d = S_BR_RDY;
        end else if (cnt_q == n_m1) begin
          cnt_d   = '0;
          st_d    = LW'(1);
          state_d = S_BF_RDP;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_BR_RDY: begin
        mem_addr = ry;
        a_d      = mem_rd_q;
        state_d  = S_BR_WRI;
      end
      S_BR_WRI: begin
        mem_we    = 1'b1;
        mem_addr  = bi;
        mem_wdata = mem_rd_q;
        state_d   = S_BR_WRY;
      end
      S_BR_WRY: begin
        mem_we    = 1'b1;
        mem_addr  = ry;
        mem_wdata = a_q;
        if (cnt_q == n_m1) begin
          cnt_d   = '0;
          st_d    = LW'(1);
          state_d = S_BF_RDP;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_BR_RDI;
        end
      end
      S_BF_RDP: begin
        mem_addr = p_addr;
        state_d  = S_BF_RDS;
      end
      S_BF_RDS: begin
        mem_addr = s_addr;
        a_d      = mem_rd_q;
        state_d  = S_BF_X;
      end
      S_BF_X: begin
        x_d     = mem_rd_q;
        term_d  = TERM_RR;
        state_d = S_BF_MUL;
      end
      S_BF_MUL: begin
        bf_ctl.mul  = 1'b1;
        bf_ctl.term = term_q;
        term_d      = term_q + 2'd1;
        if (term_q == TERM_IR) state_d = S_BF_ACC;
      end
      S_BF_ACC: state_d = S_BF_WRP;
      S_BF_WRP: begin
        mem_we    = 1'b1;
        mem_addr  = p_addr;
        mem_wdata = {sum_re, sum_im};
        state_d   = S_BF_WRS;
      end
      S_BF_WRS: begin
        mem_we    = 1'b1;
        mem_addr  = s_addr;
        mem_wdata = {dif_re, dif_im};
        if (cnt_q == half_m1) begin
          cnt_d = '0;
          if (st_q == lg) begin
            state_d = S_IDLE;
          end else begin
            st_d    = st_q + LW'(1);
            state_d = S_BF_RDP;
          end
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_BF_RDP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q   <= LOG2_POINTS_RESET;
      load_q  <= '0;
      read_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      st_q    <= LW'(1);
      term_q  <= TERM_RR;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      read_q  <= read_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      term_q  <= term_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
    end
  end

  // hold operands for the butterfly
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    x_q <= x_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rd_q <= mem[mem_addr];
  end

  r2fft_twrom #(
    .MAX_POINTS  (MAX_POINTS),
    .TWIDDLE_BITS(TWIDDLE_BITS),
    .TW_AW       (TW_AW)
  ) u_twrom (
    .clk_i (clk_i),
    .addr_i(tw_idx),
    .w_re_o(w_re),
    .w_im_o(w_im)
  );

  r2fft_bfly #(
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_bfly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bf_ctl),
    .u_re_i  (a_q[63:32]),
    .u_im_i  (a_q[31:0]),
    .x_re_i  (x_q[63:32]),
    .x_im_i  (x_q[31:0]),
    .w_re_i  (w_re),
    .w_im_i  (w_im),
    .sum_re_o(sum_re),
    .sum_im_o(sum_im),
    .dif_re_o(dif_re),
    .dif_im_o(dif_im)
  );

  // take a length change only while idle, so nothing in flight sees it
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign bin_valid_o = (state_q == S_RD_OUT);
  assign bin_re_o    = mem_rd_q[63:32];
  assign bin_im_o    = mem_rd_q[31:0];
  assign bin_index_o = 10'(idx_q);
  assign last_bin_o  = (idx_q == n_m1);

  // a bin only ever follows an accepted read
  a_bin_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o |-> $past(state_q == S_IDLE && start_i && req_type_i == REQ_READ))
    else $error("bin strobe without a read item");

  // swaps only for index below its reversed partner
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BR_WRY) |-> (bi < ry))
    else $error("bit-reversal swap out of order");

  // stage counter stays within the transform length
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BF_WRS) |-> (st_q != '0 && st_q <= lg && cnt_q <= half_m1))
    else $error("butterfly stage or index out of range");

  // load counter is clear for the whole transform
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_RD_OUT) |-> (load_q == '0))
    else $error("load count not cleared during transform");

endmodule

[tb/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import r2fft_pkg::*;

  localparam int unsigned NPTS       = 1024;
  localparam int unsigned TW_BITS    = 16;
  localparam int unsigned LG_MAX     = 10;
  localparam int unsigned STALL_MAX  = 200000;  // well above the busy time of the longest frame
  localparam longint unsigned Q62_ONE = 64'h4000_0000_0000_0000;
  localparam longint unsigned Q62_HPI = 64'h6487_ED51_10B4_611A;

  typedef struct {
    logic              kind;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } fft_item_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [9:0]         idx;
    logic               last;
  } fft_bin_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               req_type_i;
  logic signed [15:0] sample_re_i;
  logic signed [15:0] sample_im_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [3:0]         cfg_data_i;
  logic               bin_valid_o;
  logic signed [31:0] bin_re_o;
  logic signed [31:0] bin_im_o;
  logic [9:0]         bin_index_o;
  logic               last_bin_o;

  radix2_fft_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .bin_valid_o (bin_valid_o),
    .bin_re_o    (bin_re_o),
    .bin_im_o    (bin_im_o),
    .bin_index_o (bin_index_o),
    .last_bin_o  (last_bin_o)
  );

  // Items waiting for the driver, bins waiting for the DUT.
  fft_item_t pending_items[$];
  fft_bin_t  predicted_bins[$];
  int        idle_pct;
  int        errors;
  bit        item_taken;
  int        stall_cycles;

  // Predictor state: point store, counters and length register.
  int signed   store_re[NPTS];
  int signed   store_im[NPTS];
  logic [10:0] load_cnt;
  logic [10:0] read_cnt;
  logic [3:0]  len_reg;

  // Generator-side shadow of the counters, used only to keep reads legal.
  bit          written[NPTS];
  int unsigned gen_ld;
  int unsigned gen_rd;
  int unsigned gen_lg;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_len(int unsigned lg);
    if (lg < 1) return 1;
    if (lg > LG_MAX) return LG_MAX;
    return lg;
  endfunction

  // (a*b) >> 62 for a, b <= 2^62
  function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
    longint unsigned a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
    a0 = a & 64'hFFFF_FFFF; a1 = a >> 32;
    b0 = b & 64'hFFFF_FFFF; b1 = b >> 32;
    p00 = a0 * b0; p01 = a0 * b1; p10 = a1 * b0; p11 = a1 * b1;
    mid = (p00 >> 32) + (p01 & 64'hFFFF_FFFF) + (p10 & 64'hFFFF_FFFF);
    lo  = (p00 & 64'hFFFF_FFFF) | (mid << 32);
    hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  function automatic longint clamp_tw(longint v);
    longint top;
    top = (longint'(1) << (TW_BITS - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic longint q62_to_tw(longint unsigned v);
    int unsigned sh;
    sh = 63 - TW_BITS;
    return longint'((v + (64'd1 << (sh - 1))) >> sh);
  endfunction

  // W(k) = exp(-2*pi*i*k/N) in Q1.15, Taylor series on a reduced octant angle
  task automatic twiddle_q15(input int unsigned k, input int unsigned lg,
                             output longint wr, output longint wi);
    int unsigned n, q, r;
    bit swap;
    longint unsigned rr, x, x2, ct, cs, st, ss, t;
    longint cm, sm, cv, sv;
    n = 1 << lg;
    q = ((k * 4) >> lg) & 3;
    r = (k * 4) & (n - 1);
    swap = (2 * r > n);
    rr = swap ? longint'(n - r) : longint'(r);
    x = (Q62_HPI >> lg) * rr + (((Q62_HPI & longint'(n - 1)) * rr) >> lg);
    x2 = mul_q62(x, x);
    ct = Q62_ONE; cs = Q62_ONE; st = x; ss = x;
    for (longint unsigned m = 1; m <= 12; m++) begin
      t  = (2 * m - 1) * (2 * m);
      ct = mul_q62(ct, x2) / t;
      t  = (2 * m) * (2 * m + 1);
      st = mul_q62(st, x2) / t;
      if (m & 1) begin
        cs -= ct; ss -= st;
      end else begin
        cs += ct; ss += st;
      end
    end
    cm = q62_to_tw(swap ? ss : cs);
    sm = q62_to_tw(swap ? cs : ss);
    case (q)
      0: begin cv = cm;  sv = sm;  end
      1: begin cv = -sm; sv = cm;  end
      2: begin cv = -cm; sv = -sm; end
      default: begin cv = sm; sv = -cm; end
    endcase
    wr = clamp_tw(cv);
    wi = clamp_tw(-sv);
  endtask

  function automatic int signed sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Bit-reverse the store, then run every butterfly stage in place.
  task automatic transform_store(input int unsigned lg);
    int unsigned n, y, xb, half, stride, p, s;
    int signed tmp;
    longint wr, wi, ur, ui, xr, xi, vr, vi;
    n = 1 << lg;
    for (int unsigned i = 0; i < n; i++) begin
      y = 0; xb = i;
      for (int unsigned b = 0; b < lg; b++) begin
        y = (y << 1) | (xb & 1); xb >>= 1;
      end
      if (i < y) begin
        tmp = store_re[i]; store_re[i] = store_re[y]; store_re[y] = tmp;
        tmp = store_im[i]; store_im[i] = store_im[y]; store_im[y] = tmp;
      end
    end
    for (int unsigned span = 2; span <= n; span <<= 1) begin
      half = span >> 1;
      stride = n / span;
      for (int unsigned i = 0; i < n; i += span) begin
        for (int unsigned j = 0; j < half; j++) begin
          p = i + j; s = i + j + half;
          ur = store_re[p]; ui = store_im[p];
          xr = store_re[s]; xi = store_im[s];
          twiddle_q15(j * stride, lg, wr, wi);
          // floor of (x + half lsb) / 2^15: round half up
          vr = (xr * wr - xi * wi + (longint'(1) << (TW_BITS - 2))) >>> (TW_BITS - 1);
          vi = (xr * wi + xi * wr + (longint'(1) << (TW_BITS - 2))) >>> (TW_BITS - 1);
          store_re[p] = sat32(ur + vr);
          store_im[p] = sat32(ui + vi);
          store_re[s] = sat32(ur - vr);
          store_im[s] = sat32(ui - vi);
        end
      end
    end
  endtask

  // Apply one accepted item to the predictor; a read queues the bin it returns.
  task automatic fft_model_step(input fft_item_t it);
    int unsigned lg, n, idx;
    fft_bin_t bin;
    lg = clamp_len(len_reg);
    n = 1 << lg;
    if (it.kind == REQ_LOAD) begin
      idx = load_cnt & (NPTS - 1);
      store_re[idx] = it.re;
      store_im[idx] = it.im;
      load_cnt = load_cnt + 11'd1;
      if (load_cnt >= n) begin
        transform_store(lg);
        load_cnt = '0;
        read_cnt = '0;
      end
    end else begin
      idx = (read_cnt < n) ? read_cnt : 0;
      bin.re   = store_re[idx];
      bin.im   = store_im[idx];
      bin.idx  = idx[9:0];
      bin.last = (idx == n - 1);
      predicted_bins.push_back(bin);
      read_cnt = (idx + 1 >= n) ? '0 : 11'(idx + 1);
    end
  endtask

  // Queue one item and track the counters so reads only hit written entries.
  task automatic queue_item(input logic kind, input logic signed [15:0] re,
                            input logic signed [15:0] im);
    fft_item_t it;
    int unsigned n, idx;
    n = 1 << gen_lg;
    it.kind = kind; it.re = re; it.im = im;
    pending_items.push_back(it);
    if (kind == REQ_LOAD) begin
      written[gen_ld & (NPTS - 1)] = 1'b1;
      gen_ld = (gen_ld + 1) & 11'h7FF;
      if (gen_ld >= n) begin
        gen_ld = 0; gen_rd = 0;
      end
    end else begin
      idx = (gen_rd < n) ? gen_rd : 0;
      gen_rd = (idx + 1 >= n) ? 0 : idx + 1;
    end
  endtask

  function automatic bit read_is_legal();
    int unsigned n;
    n = 1 << gen_lg;
    return written[(gen_rd < n) ? gen_rd : 0];
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_load();
    queue_item(REQ_LOAD, rand_sample(), rand_sample());
  endtask

  // A read is only queued when it hits a written entry; otherwise load instead.
  task automatic queue_read();
    if (read_is_legal()) begin
      queue_item(REQ_READ, 16'($urandom), 16'($urandom));
    end else begin
      queue_load();
    end
  endtask

  // Mostly whole frames then a run of reads, some loose items; only loose if frames_ok clear.
  task automatic queue_random(input int count, input bit frames_ok);
    int unsigned n, burst;
    n = 1 << gen_lg;
    while (count > 0) begin
      if (frames_ok && $urandom_range(99) < 85) begin
        do begin
          queue_load();
          count--;
        end while (gen_ld != 0);
        burst = $urandom_range(1, n + 2);
        repeat (burst) queue_read();
        count -= burst;
      end else begin
        if ($urandom_range(1)) queue_read();
        else queue_load();
        count--;
      end
    end
  endtask

  // Hold until every item is in and every bin is out, then let the DUT settle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || start_i || predicted_bins.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [3:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    gen_lg = clamp_len(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: advance to the next item once the current one is taken.
  always @(negedge clk_i) begin
    fft_item_t it;
    if (rst_ni && (!start_i || item_taken)) begin
      item_taken = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = pending_items.pop_front();
        req_type_i  <= it.kind;
        sample_re_i <= it.re;
        sample_im_i <= it.im;
        start_i     <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check bins first, then feed accepted items and writes to the predictor.
  always @(posedge clk_i) begin
    fft_item_t it;
    fft_bin_t  want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (bin_valid_o) begin
        moved = 1'b1;
        if (predicted_bins.size() == 0) begin
          $error("bin with no item waiting: index %0d", bin_index_o);
          errors++;
        end else begin
          want = predicted_bins.pop_front();
          if (bin_re_o !== want.re) begin
            $error("bin_re: expected %0d, got %0d", want.re, bin_re_o);
            errors++;
          end
          if (bin_im_o !== want.im) begin
            $error("bin_im: expected %0d, got %0d", want.im, bin_im_o);
            errors++;
          end
          if (bin_index_o !== want.idx) begin
            $error("bin_index: expected %0d, got %0d", want.idx, bin_index_o);
            errors++;
          end
          if (last_bin_o !== want.last) begin
            $error("last_bin: expected %0d, got %0d", want.last, last_bin_o);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        moved = 1'b1;
        item_taken = 1'b1;
        it.kind = req_type_i; it.re = sample_re_i; it.im = sample_im_i;
        fft_model_step(it);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        len_reg = cfg_data_i;
      end
    end
    // Drop the run if nothing moves for far longer than the longest transform.
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Length settings per phase; 0 and 15 are out of range and clamp.
  logic [3:0] phase_len [12] = '{4'd0, 4'd3, 4'd2, 4'd15, 4'd4, 4'd5,
                                  4'd1, 4'd6, 4'd10, 4'd3, 4'd2, 4'd5};

  initial begin
    errors = 0; stall_cycles = 0; item_taken = 1'b0; idle_pct = 9;
    start_i = 1'b0; req_type_i = REQ_LOAD; sample_re_i = '0; sample_im_i = '0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    load_cnt = '0; read_cnt = '0; len_reg = LOG2_POINTS_RESET;
    gen_ld = 0; gen_rd = 0; gen_lg = clamp_len(LOG2_POINTS_RESET);
    foreach (store_re[i]) begin
      store_re[i] = 0; store_im[i] = 0; written[i] = 1'b0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: two-point frames with full-scale samples, an early read,
    // wrap of the bin counter and the last flag.
    write_len(4'd1);
    queue_item(REQ_LOAD, 16'sh7FFF, 16'sh8000);
    queue_item(REQ_READ, 16'sh0000, 16'sh0000);
    queue_item(REQ_LOAD, 16'sh8000, 16'sh7FFF);
    repeat (3) queue_item(REQ_READ, 16'shFFFF, 16'shFFFF);
    queue_item(REQ_LOAD, 16'sh7FFF, 16'sh7FFF);
    queue_item(REQ_LOAD, 16'sh7FFF, 16'sh7FFF);
    repeat (2) queue_item(REQ_READ, 16'sh0000, 16'sh0000);
    queue_item(REQ_LOAD, 16'sh8000, 16'sh8000);
    queue_item(REQ_LOAD, 16'sh8000, 16'sh8000);
    repeat (2) queue_item(REQ_READ, 16'sh0000, 16'sh0000);

    // Random phases; a length change leaves stale counters behind on purpose.
    foreach (phase_len[p]) begin
      idle_pct = (p < 4) ? 9 : (p < 8) ? 73 : 0;
      write_len(phase_len[p]);
      if (clamp_len(phase_len[p]) == LG_MAX) begin
        // full length: loose items only, no complete frame
        queue_random(12, 1'b0);
      end else begin
        queue_random(24, 1'b1);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
